FILE: sv/lrt_pkg.sv
// types and constants shared by the line receiver modules
`timescale 1ns / 1ps

package lrt_pkg;

    // request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_POLL  = 1'b1;

    // end status codes
    localparam logic [1:0] ST_COMPLETE = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_SILENCE  = 2'd2;
    localparam logic [1:0] ST_CUT      = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_MAX_LEN         = 2'd0;
    localparam logic [1:0] CFG_IDLE_POLL_LIMIT = 2'd1;
    localparam logic [1:0] CFG_IDLE_TICK_LIMIT = 2'd2;
    localparam logic [1:0] CFG_CLOCK_PRESENT   = 2'd3;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;

    localparam logic [8:0]  MAX_LEN_RESET    = 9'd256;
    localparam logic [31:0] IDLE_POLL_RESET  = 32'd1000;

    typedef struct packed {
        logic        clock_present;
        logic [31:0] idle_tick_limit;
        logic [31:0] idle_poll_limit;
        logic [8:0]  max_len;
    } cfg_t;

    typedef struct packed {
        logic [63:0] now_time;
        logic [7:0]  byte_value;
        logic        byte_ready;
        logic        req_type;
    } req_t;

    typedef struct packed {
        logic [7:0] line_length;
        logic [1:0] end_status;
        logic       line_done;
        logic [7:0] store_char;
        logic [7:0] store_index;
        logic       store_valid;
    } res_t;

endpackage

FILE: sv/line_receiver_with_timeouts_top.sv
// top level of the line receiver with idle and tick timeouts
`timescale 1ns / 1ps

// Receives one text line from a polled byte source. Each request on the
// s_ channel is either a start (opens a line, clears the counts, latches
// the tick) or one poll of the source with its readiness, byte and tick.
// Every request gives exactly one result on the m_ channel: a stored byte
// with its index, the end of the line with its status and length (tlast),
// or an empty result. The user must write registers on the cfg_ channel
// only while the block is idle; the block does not enforce this and always
// accepts writes. A request passes through the input register, then the
// decision logic into the result register.
// Throughput is one request per cycle while the result side does not stall;
// the line state updates in a single pass, so back-to-back requests never
// wait on each other. When the result side stalls, the result register holds
// and the input register can take one more request before s_tready drops.
// Reset clears the line state (no line open) and loads the register
// defaults; no clearing pass is needed.

module line_receiver_with_timeouts_top #(
    parameter int MAX_LINE    = 256,
    parameter int LINE_FACTOR = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // byte_value[7:0], now_time[71:8]
    input  logic [1:0]  s_tuser,   // req_type[0], byte_ready[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // store_index[7:0], store_char[15:8], line_length[23:16]
    output logic [2:0]  m_tuser,   // store_valid[0], end_status[2:1]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import lrt_pkg::*;

    localparam int LF_W   = $clog2(LINE_FACTOR + 1);
    localparam int PROD_W = 32 + LF_W;

    cfg_t              cfg;
    logic [PROD_W-1:0] poll_bound;
    logic [PROD_W-1:0] tick_bound;
    logic              in_valid_reg;
    req_t              in_req_reg;
    logic              in_take;
    logic              out_valid;
    res_t              out_res;

    assign s_tready = !in_valid_reg || in_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg.req_type   <= s_tuser[0];
            in_req_reg.byte_ready <= s_tuser[1];
            in_req_reg.byte_value <= s_tdata[7:0];
            in_req_reg.now_time   <= s_tdata[71:8];
        end
    end

    lrt_cfg #(
        .LINE_FACTOR (LINE_FACTOR),
        .PROD_W      (PROD_W)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .poll_bound (poll_bound),
        .tick_bound (tick_bound)
    );

    lrt_core #(
        .MAX_LINE (MAX_LINE),
        .PROD_W   (PROD_W)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .poll_bound (poll_bound),
        .tick_bound (tick_bound),
        .in_valid   (in_valid_reg),
        .in_req     (in_req_reg),
        .in_take    (in_take),
        .m_valid    (out_valid),
        .m_ready    (m_tready),
        .m_res      (out_res)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {out_res.line_length, out_res.store_char, out_res.store_index};
    assign m_tuser  = {out_res.end_status, out_res.store_valid};
    assign m_tlast  = out_res.line_done;

    // a result never both stores a byte and ends the line
    a_store_xor_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tlast))
        else $error("result stores a byte and ends the line");

    // status and length stay zero unless the line ends
    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tuser[2:1] == ST_COMPLETE && m_tdata[23:16] == 8'd0))
        else $error("end fields set without line end");

    // a held request in the input register is not lost or overwritten
    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_take) |=> (in_valid_reg && $stable(in_req_reg)))
        else $error("pending request dropped");

endmodule

FILE: sv/lrt_cfg.sv
// configuration registers and the precomputed overall bounds
`timescale 1ns / 1ps

module lrt_cfg #(
    parameter int LINE_FACTOR = 4,
    parameter int PROD_W      = 35
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output lrt_pkg::cfg_t      cfg,
    output logic [PROD_W-1:0]  poll_bound,
    output logic [PROD_W-1:0]  tick_bound
);
    import lrt_pkg::*;

    cfg_t              cfg_reg;
    logic [PROD_W-1:0] poll_bound_reg;
    logic [PROD_W-1:0] tick_bound_reg;
    logic [PROD_W-1:0] data_prod;

    assign cfg_ready = 1'b1;
    // bounds are formed once at write time, no wrap
    assign data_prod = PROD_W'(cfg_data) * PROD_W'(LINE_FACTOR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_len         <= MAX_LEN_RESET;
            cfg_reg.idle_poll_limit <= IDLE_POLL_RESET;
            cfg_reg.idle_tick_limit <= '0;
            cfg_reg.clock_present   <= 1'b0;
            poll_bound_reg          <= PROD_W'(IDLE_POLL_RESET) * PROD_W'(LINE_FACTOR);
            tick_bound_reg          <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MAX_LEN: begin
                    cfg_reg.max_len <= cfg_data[8:0];
                end
                CFG_IDLE_POLL_LIMIT: begin
                    cfg_reg.idle_poll_limit <= cfg_data;
                    poll_bound_reg          <= data_prod;
                end
                CFG_IDLE_TICK_LIMIT: begin
                    cfg_reg.idle_tick_limit <= cfg_data;
                    tick_bound_reg          <= data_prod;
                end
                CFG_CLOCK_PRESENT: begin
                    cfg_reg.clock_present <= cfg_data[0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign cfg        = cfg_reg;
    assign poll_bound = poll_bound_reg;
    assign tick_bound = tick_bound_reg;

endmodule

FILE: sv/lrt_core.sv
// line state, per-request decision logic and the result register
`timescale 1ns / 1ps

module lrt_core #(
    parameter int MAX_LINE = 256,
    parameter int PROD_W   = 35
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lrt_pkg::cfg_t      cfg,
    input  logic [PROD_W-1:0]  poll_bound,
    input  logic [PROD_W-1:0]  tick_bound,
    input  logic               in_valid,
    input  lrt_pkg::req_t      in_req,
    output logic               in_take,
    output logic               m_valid,
    input  logic               m_ready,
    output lrt_pkg::res_t      m_res
);
    import lrt_pkg::*;

    localparam logic [8:0] CAP_LIMIT = (MAX_LINE < 256) ? 9'(MAX_LINE) : 9'd256;

    logic        active_reg, active_next;
    logic [7:0]  char_count_reg, char_count_next;
    logic [31:0] idle_count_reg, idle_count_next;
    logic [31:0] poll_total_reg, poll_total_next;
    logic [63:0] start_time_reg, start_time_next;
    logic [63:0] last_time_reg, last_time_next;
    logic        m_valid_reg;
    res_t        res_reg, res_next;

    logic [8:0]  cap;
    logic [31:0] idle_inc, poll_inc;
    logic [63:0] gap_last, gap_start;
    logic        timed, over_idle, over_polls, over_tick_last, over_tick_start;
    logic [1:0]  quiet_status;

    assign in_take = in_valid && (!m_valid_reg || m_ready);

    assign cap       = (cfg.max_len > CAP_LIMIT) ? CAP_LIMIT : cfg.max_len;
    assign timed     = cfg.clock_present && (cfg.idle_tick_limit != '0);
    assign idle_inc  = (&idle_count_reg) ? idle_count_reg : idle_count_reg + 32'd1;
    assign poll_inc  = (&poll_total_reg) ? poll_total_reg : poll_total_reg + 32'd1;
    assign gap_last  = in_req.now_time - last_time_reg;
    assign gap_start = in_req.now_time - start_time_reg;

    assign over_idle       = idle_inc > cfg.idle_poll_limit;
    assign over_polls      = PROD_W'(poll_inc) > poll_bound;
    assign over_tick_last  = gap_last > 64'(cfg.idle_tick_limit);
    assign over_tick_start = gap_start > 64'(tick_bound);
    assign quiet_status    = (char_count_reg == '0) ? ST_SILENCE : ST_CUT;

    always_comb begin
        active_next     = active_reg;
        char_count_next = char_count_reg;
        idle_count_next = idle_count_reg;
        poll_total_next = poll_total_reg;
        start_time_next = start_time_reg;
        last_time_next  = last_time_reg;
        res_next        = '0;

        if (in_req.req_type == REQ_START) begin
            active_next     = 1'b1;
            char_count_next = '0;
            idle_count_next = '0;
            poll_total_next = '0;
            start_time_next = in_req.now_time;
            last_time_next  = in_req.now_time;
            if (cap == '0) begin
                active_next         = 1'b0;
                res_next.line_done  = 1'b1;
                res_next.end_status = ST_TOO_LONG;
            end
        end else if (active_reg) begin
            if (!in_req.byte_ready) begin
                idle_count_next = idle_inc;
                if (over_idle) begin
                    active_next          = 1'b0;
                    res_next.line_done   = 1'b1;
                    res_next.end_status  = quiet_status;
                    res_next.line_length = char_count_reg;
                end else begin
                    poll_total_next = poll_inc;
                    if (over_polls || (timed && (over_tick_last || over_tick_start))) begin
                        active_next          = 1'b0;
                        res_next.line_done   = 1'b1;
                        res_next.end_status  = quiet_status;
                        res_next.line_length = char_count_reg;
                    end
                end
            end else begin
                idle_count_next = '0;
                poll_total_next = poll_inc;
                if (over_polls) begin
                    // ends cut short even with nothing stored
                    active_next          = 1'b0;
                    res_next.line_done   = 1'b1;
                    res_next.end_status  = ST_CUT;
                    res_next.line_length = char_count_reg;
                end else begin
                    last_time_next = in_req.now_time;
                    if (timed && over_tick_start) begin
                        active_next          = 1'b0;
                        res_next.line_done   = 1'b1;
                        res_next.end_status  = ST_CUT;
                        res_next.line_length = char_count_reg;
                    end else if (in_req.byte_value == CH_NEWLINE) begin
                        active_next          = 1'b0;
                        res_next.line_done   = 1'b1;
                        res_next.end_status  = ST_COMPLETE;
                        res_next.line_length = char_count_reg;
                    end else if (in_req.byte_value == CH_RETURN) begin
                        active_next = active_reg;
                    end else if ({1'b0, char_count_reg} + 9'd1 >= cap) begin
                        // no room left for the terminator
                        active_next          = 1'b0;
                        res_next.line_done   = 1'b1;
                        res_next.end_status  = ST_TOO_LONG;
                        res_next.line_length = char_count_reg;
                    end else begin
                        res_next.store_valid = 1'b1;
                        res_next.store_index = char_count_reg;
                        res_next.store_char  = in_req.byte_value;
                        char_count_next      = char_count_reg + 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            char_count_reg <= '0;
            idle_count_reg <= '0;
            poll_total_reg <= '0;
            start_time_reg <= '0;
            last_time_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (in_take) begin
                active_reg     <= active_next;
                char_count_reg <= char_count_next;
                idle_count_reg <= idle_count_next;
                poll_total_reg <= poll_total_next;
                start_time_reg <= start_time_next;
                last_time_reg  <= last_time_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = res_reg;

endmodule
